// ===== hdl/sqwsg_pkg.sv =====
// Shared types, constants and the attenuation table of the square wave sound generator.
// No dependencies; sqwsg_ctrl, sqwsg_dp and the top level refer to it by scoped names.
package sqwsg_pkg;

    localparam int TONE_CHANNELS = 3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;
    localparam int PERIOD_W   = 10;
    localparam int ATTEN_W    = 4;
    localparam int LFSR_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int REM_W      = CFG_DATA_W + 1;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_DIV   = 1'b1;

    // Request opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [CFG_DATA_W-1:0] CLOCK_STEP_RST = 18'd223721;
    localparam logic [CFG_DATA_W-1:0] TICK_DIV_RST   = 18'd44100;
    localparam logic [LFSR_W-1:0]     LFSR_SEED      = 16'h8000;
    localparam logic [ATTEN_W-1:0]    ATTEN_SILENT   = 4'hF;

    localparam logic [1:0] NOISE_CH = 2'd3;

    // Noise counter reload per rate code
    localparam logic [1:0] NOISE_RATE_0   = 2'd0;
    localparam logic [1:0] NOISE_RATE_1   = 2'd1;
    localparam logic [1:0] NOISE_RATE_2   = 2'd2;
    localparam logic [PERIOD_W-1:0] NOISE_RELOAD_0 = 10'h010;
    localparam logic [PERIOD_W-1:0] NOISE_RELOAD_1 = 10'h020;
    localparam logic [PERIOD_W-1:0] NOISE_RELOAD_2 = 10'h040;

    typedef struct packed {
        logic wr;      // apply a command byte
        logic load;    // add the clock step to the remainder
        logic tick;    // run one chip tick, take the tick divisor off the remainder
        logic finish;  // register the mix as the result
    } t_ctrl_cmd;

    typedef struct packed {
        logic more;      // remainder still holds at least one tick
        logic out_free;  // result register can take a new value
    } t_ctrl_sts;

    // Amplitude for each attenuation step
    function automatic logic [SAMPLE_W-1:0] amp_of(input logic [ATTEN_W-1:0] att);
        logic [SAMPLE_W-1:0] a;
        case (att)
            4'd0:    a = 16'd8191;
            4'd1:    a = 16'd6507;
            4'd2:    a = 16'd5168;
            4'd3:    a = 16'd4105;
            4'd4:    a = 16'd3261;
            4'd5:    a = 16'd2590;
            4'd6:    a = 16'd2057;
            4'd7:    a = 16'd1642;
            4'd8:    a = 16'd1298;
            4'd9:    a = 16'd1031;
            4'd10:   a = 16'd819;
            4'd11:   a = 16'd651;
            4'd12:   a = 16'd517;
            4'd13:   a = 16'd411;
            4'd14:   a = 16'd326;
            default: a = 16'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== hdl/sqwsg_req_if.sv =====
// Request channel of the square wave sound generator: valid/ready plus opcode and byte.
// Depends on nothing.
interface sqwsg_req_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data;

    modport source (output valid, output op, output data, input ready);
    modport sink   (input valid, input op, input data, output ready);
endinterface

// ===== hdl/sqwsg_rsp_if.sv =====
// Result channel of the square wave sound generator: valid/ready plus the signed sample.
// Depends on nothing.
interface sqwsg_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ===== hdl/sqwsg_ctrl.sv =====
// Sequencer of the square wave sound generator: accepts requests and steps the tick loop.
// Depends on sqwsg_pkg.
module sqwsg_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_op,
    output logic                  o_req_ready,
    input  sqwsg_pkg::t_ctrl_sts  i_sts,
    output sqwsg_pkg::t_ctrl_cmd  o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    if (i_req_op == sqwsg_pkg::OP_SAMPLE) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_RUN;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                if (i_sts.more) begin
                    o_cmd.tick = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_tick_needs_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.tick |-> i_sts.more)
        else $error("tick issued with remainder below sample rate");
    a_finish_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_sts.out_free && !i_sts.more)
        else $error("result written over a pending one or before ticks ran out");
    a_finish_frees_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> o_req_ready)
        else $error("request side not reopened after a sample");
`endif

endmodule

// ===== hdl/sqwsg_dp.sv =====
// Datapath of the square wave sound generator: chip registers, tick logic, mixer, result register.
// Depends on sqwsg_pkg.
module sqwsg_dp #(
    parameter int TONE_CHANNELS = sqwsg_pkg::TONE_CHANNELS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [sqwsg_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sqwsg_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic [7:0]                            i_data,
    input  sqwsg_pkg::t_ctrl_cmd                  i_cmd,
    output sqwsg_pkg::t_ctrl_sts                  o_sts,
    output logic                                  o_rsp_valid,
    input  logic                                  i_rsp_ready,
    output logic signed [sqwsg_pkg::SAMPLE_W-1:0] o_rsp_sample
);

    localparam int PW = sqwsg_pkg::PERIOD_W;
    localparam int RW = sqwsg_pkg::REM_W;
    localparam int SW = sqwsg_pkg::SAMPLE_W;

    logic [sqwsg_pkg::CFG_DATA_W-1:0] r_clock_step;
    logic [sqwsg_pkg::CFG_DATA_W-1:0] r_tick_div;
    logic [RW-1:0]                    r_clock_rem;

    logic [PW-1:0] r_tone_period [TONE_CHANNELS];
    logic [PW-1:0] r_tone_count  [TONE_CHANNELS];
    logic          r_tone_level  [TONE_CHANNELS];
    logic [sqwsg_pkg::ATTEN_W-1:0] r_atten [4];

    logic [2:0]                     r_noise_mode;
    logic [PW-1:0]                  r_noise_count;
    logic [sqwsg_pkg::LFSR_W-1:0]   r_noise_lfsr;
    logic                           r_noise_phase;
    logic [1:0]                     r_lat_ch;
    logic                           r_lat_vol;

    logic                 r_out_valid;
    logic signed [SW-1:0] r_sample;

    // Command byte decode
    logic       byte_latch;
    logic [1:0] dec_ch;
    logic       dec_vol;

    // Tick logic
    logic [sqwsg_pkg::CFG_DATA_W-1:0] rate_eff;
    logic [PW-1:0] n_tone_count [TONE_CHANNELS];
    logic          tone_wrap    [TONE_CHANNELS];
    logic [PW-1:0] noise_dec;
    logic [PW-1:0] noise_reload;
    logic          noise_fb;

    logic signed [SW-1:0] mix;
    logic signed [SW-1:0] amp;

    assign byte_latch = i_data[7];
    assign dec_ch     = byte_latch ? i_data[6:5] : r_lat_ch;
    assign dec_vol    = byte_latch ? i_data[4]   : r_lat_vol;

    assign rate_eff = (r_tick_div == '0) ? sqwsg_pkg::CFG_DATA_W'(1) : r_tick_div;

    always_comb begin
        for (int i = 0; i < TONE_CHANNELS; i++) begin
            n_tone_count[i] = (r_tone_count[i] != '0) ? r_tone_count[i] - PW'(1) : '0;
            tone_wrap[i]    = (n_tone_count[i] == '0);
        end
    end

    assign noise_dec = (r_noise_count != '0) ? r_noise_count - PW'(1) : '0;

    always_comb begin
        case (r_noise_mode[1:0])
            sqwsg_pkg::NOISE_RATE_0: noise_reload = sqwsg_pkg::NOISE_RELOAD_0;
            sqwsg_pkg::NOISE_RATE_1: noise_reload = sqwsg_pkg::NOISE_RELOAD_1;
            sqwsg_pkg::NOISE_RATE_2: noise_reload = sqwsg_pkg::NOISE_RELOAD_2;
            default: begin
                noise_reload = (r_tone_period[TONE_CHANNELS-1] != '0)
                             ? r_tone_period[TONE_CHANNELS-1] : PW'(1);
            end
        endcase
    end

    // White mode taps bits 0 and 3, periodic mode recirculates bit 0
    assign noise_fb = r_noise_mode[2] ? (r_noise_lfsr[0] ^ r_noise_lfsr[3]) : r_noise_lfsr[0];

    always_comb begin
        mix = '0;
        amp = '0;
        for (int i = 0; i < TONE_CHANNELS; i++) begin
            amp = signed'(sqwsg_pkg::amp_of(r_atten[i]));
            mix = r_tone_level[i] ? mix + amp : mix - amp;
        end
        amp = signed'(sqwsg_pkg::amp_of(r_atten[sqwsg_pkg::NOISE_CH]));
        mix = r_noise_lfsr[0] ? mix + amp : mix - amp;
    end

    assign o_sts.more     = (r_clock_rem >= {1'b0, rate_eff});
    assign o_sts.out_free = !r_out_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_step  <= sqwsg_pkg::CLOCK_STEP_RST;
            r_tick_div    <= sqwsg_pkg::TICK_DIV_RST;
            r_clock_rem   <= '0;
            for (int i = 0; i < TONE_CHANNELS; i++) begin
                r_tone_period[i] <= '0;
                r_tone_count[i]  <= '0;
                r_tone_level[i]  <= 1'b0;
            end
            for (int i = 0; i < 4; i++) begin
                r_atten[i] <= sqwsg_pkg::ATTEN_SILENT;
            end
            r_noise_mode  <= '0;
            r_noise_count <= '0;
            r_noise_lfsr  <= sqwsg_pkg::LFSR_SEED;
            r_noise_phase <= 1'b0;
            r_lat_ch      <= '0;
            r_lat_vol     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sqwsg_pkg::CFG_CLOCK_STEP: r_clock_step <= i_cfg_wdata;
                    sqwsg_pkg::CFG_TICK_DIV:   r_tick_div   <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (i_cmd.wr) begin
                if (byte_latch) begin
                    r_lat_ch  <= i_data[6:5];
                    r_lat_vol <= i_data[4];
                end
                if (dec_vol) begin
                    r_atten[dec_ch] <= i_data[3:0];
                end else if (dec_ch == sqwsg_pkg::NOISE_CH) begin
                    // Any noise control write reseeds the shift register
                    r_noise_mode <= i_data[2:0];
                    r_noise_lfsr <= sqwsg_pkg::LFSR_SEED;
                end else begin
                    for (int i = 0; i < TONE_CHANNELS; i++) begin
                        if (dec_ch == 2'(i)) begin
                            r_tone_period[i] <= byte_latch
                                ? {r_tone_period[i][PW-1:4], i_data[3:0]}
                                : {i_data[5:0], r_tone_period[i][3:0]};
                        end
                    end
                end
            end

            if (i_cmd.load) begin
                r_clock_rem <= r_clock_rem + {1'b0, r_clock_step};
            end

            if (i_cmd.tick) begin
                r_clock_rem <= r_clock_rem - {1'b0, rate_eff};
                for (int i = 0; i < TONE_CHANNELS; i++) begin
                    if (tone_wrap[i]) begin
                        r_tone_count[i] <= r_tone_period[i];
                        r_tone_level[i] <= !r_tone_level[i];
                    end else begin
                        r_tone_count[i] <= n_tone_count[i];
                    end
                end
                if (noise_dec == '0) begin
                    r_noise_count <= noise_reload;
                    r_noise_phase <= !r_noise_phase;
                    if (!r_noise_phase) begin
                        r_noise_lfsr <= {noise_fb, r_noise_lfsr[sqwsg_pkg::LFSR_W-1:1]};
                    end
                end else begin
                    r_noise_count <= noise_dec;
                end
            end

            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_sample <= mix;
        end
    end

    assign o_rsp_valid  = r_out_valid;
    assign o_rsp_sample = r_sample;

`ifndef SYNTHESIS
    a_rem_below_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> !r_clock_rem[RW-1])
        else $error("clock remainder left at or above the tick divisor range");
`endif

endmodule

// ===== hdl/square_wave_sound_generator_unit.sv =====
// Top level of the square wave sound generator: request/result channels and configuration port.
// Depends on sqwsg_pkg, sqwsg_req_if, sqwsg_rsp_if, sqwsg_ctrl and sqwsg_dp.
//
// Usage:
//   i_req carries one request per handshake: op = write takes data as a command byte
//   (latch or data byte, as on the classic three-tone/one-noise chip), op = sample
//   advances the chip clock and returns one signed mix on o_rsp. Writes give no result.
//   i_cfg_we/i_cfg_idx/i_cfg_wdata set the clock step (index 0) and the tick divisor
//   (index 1); write them only while the block is idle.
// Sequence:
//   A sample request adds the clock step to the clock remainder; the subtract-and-compare
//   on the remainder then runs one chip tick per cycle, taking the tick divisor off each
//   time, for ticks = (remainder + clock step) / tick divisor ticks (a zero divisor counts
//   as one), and the mix is then registered as the result. Requests are taken only
//   while no sample is in work.
// Reset (synchronous, active low): all voices silent, periods and counters zero, noise
//   shift register seeded, clock step and tick divisor back to their default values.
// Stall: the result register holds a sample until o_rsp.ready; a new request is still
//   accepted meanwhile, and the next sample waits at its end until the register frees.
module square_wave_sound_generator_unit #(
    parameter int TONE_CHANNELS = sqwsg_pkg::TONE_CHANNELS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    sqwsg_req_if.sink                        i_req,
    sqwsg_rsp_if.source                      o_rsp,
    input  logic                             i_cfg_we,
    input  logic [sqwsg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sqwsg_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    sqwsg_pkg::t_ctrl_cmd cmd;
    sqwsg_pkg::t_ctrl_sts sts;

    // Sequencer: owns the request handshake and walks the tick loop
    sqwsg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_op    (i_req.op),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: chip state, tick and mix logic, result register
    sqwsg_dp #(
        .TONE_CHANNELS (TONE_CHANNELS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_data       (i_req.data),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_rsp_valid  (o_rsp.valid),
        .i_rsp_ready  (o_rsp.ready),
        .o_rsp_sample (o_rsp.sample)
    );

endmodule
